>>> rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int NUM_TERMINALS_DEF = 4;
    localparam int COLUMNS_DEF       = 80;
    localparam int ROWS_DEF          = 25;
    localparam int TAB_SPACES_DEF    = 4;

    localparam int FUNC_W     = 2;
    localparam int TERM_IN_W  = 2;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int CELL_W     = 16;

    localparam logic [CHAR_W-1:0] ATTR_NORMAL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] GLYPH_RESET = 8'd95;

    localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_NORMAL, CH_SPACE};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT       = 2'd0,
        FUNC_BACKSPACE = 2'd1,
        FUNC_READ      = 2'd2,
        FUNC_NONE      = 2'd3
    } tcw_func_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_DATA,
        ST_BLANK,
        ST_PUT,
        ST_SCROLL_COPY,
        ST_SCROLL_FILL,
        ST_GLYPH,
        ST_RESULT
    } tcw_state_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] cursor_col;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [CHAR_W-1:0]    cell_char;
        logic [CHAR_W-1:0]    cell_attr;
        logic                 scrolled;
    } tcw_result_t;

endpackage

>>> rtl/tcw_if.sv
interface tcw_req_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [TERM_IN_W-1:0] terminal;
    logic [CHAR_W-1:0]    char_code;
    logic [INDEX_W-1:0]   cell_index;

    modport source (output valid, output func, output terminal, output char_code,
                    output cell_index, input ready);
    modport sink (input valid, input func, input terminal, input char_code,
                  input cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [CHAR_W-1:0]    cell_char;
    logic [CHAR_W-1:0]    cell_attr;
    logic                 scrolled;

    modport source (output valid, output cursor_col, output cursor_row, output cell_char,
                    output cell_attr, output scrolled, input ready);
    modport sink (input valid, input cursor_col, input cursor_row, input cell_char,
                  input cell_attr, input scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tcw_cell_mem.sv
module tcw_cell_mem import tcw_pkg::*; #(
    parameter int DEPTH  = NUM_TERMINALS_DEF * ROWS_DEF * COLUMNS_DEF,
    parameter int ADDR_W = $clog2(NUM_TERMINALS_DEF * ROWS_DEF * COLUMNS_DEF)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; #(
    parameter int NUM_TERMINALS = NUM_TERMINALS_DEF,
    parameter int COLUMNS       = COLUMNS_DEF,
    parameter int ROWS          = ROWS_DEF,
    parameter int TAB_SPACES    = TAB_SPACES_DEF,
    parameter int ADDR_W        = $clog2(NUM_TERMINALS_DEF * ROWS_DEF * COLUMNS_DEF)
) (
    input  logic              clk,
    input  logic              rst_n,
    tcw_req_if.sink           req,
    input  logic [CHAR_W-1:0] glyph,
    output logic              res_valid,
    input  logic              res_ready,
    output tcw_result_t       res,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [CELL_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [CELL_W-1:0] mem_rdata
);

    localparam int SCREEN_CELLS = ROWS * COLUMNS;
    localparam int TOTAL_CELLS  = NUM_TERMINALS * SCREEN_CELLS;
    localparam int MOVE_CELLS   = SCREEN_CELLS - COLUMNS;
    localparam int TERM_W       = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int ROW_W        = $clog2(ROWS);
    localparam int SCR_W        = $clog2(SCREEN_CELLS + 1);
    localparam int TAB_W        = $clog2(TAB_SPACES + 1);

    tcw_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [COL_W-1:0]  cur_col_reg [NUM_TERMINALS];
    logic [ROW_W-1:0]  cur_row_reg [NUM_TERMINALS];
    logic              cur_we;

    tcw_func_t         func_reg, func_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic              term_bad_reg, term_bad_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              is_tab_reg, is_tab_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [TAB_W-1:0]  tab_reg, tab_next;
    logic [SCR_W-1:0]  scr_cnt_reg, scr_cnt_next;
    logic              scrolled_reg, scrolled_next;
    logic [CHAR_W-1:0] rd_char_reg, rd_char_next;
    logic [CHAR_W-1:0] rd_attr_reg, rd_attr_next;

    logic              term_ok;
    logic [TERM_W-1:0] term_in;
    logic [ADDR_W-1:0] base_in;
    logic              index_ok;
    logic [ADDR_W-1:0] cur_addr;
    logic              col_last;
    logic              row_last;

    assign term_ok  = 32'(req.terminal) < 32'(NUM_TERMINALS);
    assign term_in  = TERM_W'(req.terminal);
    assign base_in  = ADDR_W'(term_in) * ADDR_W'(SCREEN_CELLS);
    assign index_ok = 32'(req.cell_index) < 32'(SCREEN_CELLS);
    assign cur_addr = base_reg + ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign col_last = col_reg == COL_W'(COLUMNS - 1);
    assign row_last = row_reg == ROW_W'(ROWS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < NUM_TERMINALS; i++)
            begin
                cur_col_reg[i] <= '0;
                cur_row_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cur_we)
            begin
                cur_col_reg[term_reg] <= col_reg;
                cur_row_reg[term_reg] <= row_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        term_reg     <= term_next;
        term_bad_reg <= term_bad_next;
        ch_reg       <= ch_next;
        is_tab_reg   <= is_tab_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        base_reg     <= base_next;
        tab_reg      <= tab_next;
        scr_cnt_reg  <= scr_cnt_next;
        scrolled_reg <= scrolled_next;
        rd_char_reg  <= rd_char_next;
        rd_attr_reg  <= rd_attr_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        func_next     = func_reg;
        term_next     = term_reg;
        term_bad_next = term_bad_reg;
        ch_next       = ch_reg;
        is_tab_next   = is_tab_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        tab_next      = tab_reg;
        scr_cnt_next  = scr_cnt_reg;
        scrolled_next = scrolled_reg;
        rd_char_next  = rd_char_reg;
        rd_attr_next  = rd_attr_reg;

        req.ready = 1'b0;
        res_valid = 1'b0;
        cur_we    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = BLANK_CELL;
        mem_re    = 1'b0;
        mem_raddr = base_in + ADDR_W'(req.cell_index);

        res = '0;
        if (!term_bad_reg)
        begin
            res.cursor_col = COL_OUT_W'(col_reg);
            res.cursor_row = ROW_OUT_W'(row_reg);
            res.cell_char  = rd_char_reg;
            res.cell_attr  = rd_attr_reg;
            res.scrolled   = scrolled_reg;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == ADDR_W'(TOTAL_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    func_next     = tcw_func_t'(req.func);
                    term_next     = term_in;
                    term_bad_next = !term_ok;
                    ch_next       = req.char_code;
                    is_tab_next   = req.char_code == CH_TAB;
                    base_next     = base_in;
                    scrolled_next = 1'b0;
                    rd_char_next  = '0;
                    rd_attr_next  = '0;
                    col_next      = '0;
                    row_next      = '0;
                    if (req.char_code == CH_TAB)
                    begin
                        tab_next = TAB_W'(TAB_SPACES);
                    end
                    else if (req.char_code == CH_NEWLINE)
                    begin
                        tab_next = '0;
                    end
                    else
                    begin
                        tab_next = TAB_W'(1);
                    end

                    if (!term_ok)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        col_next = cur_col_reg[term_in];
                        row_next = cur_row_reg[term_in];
                        unique case (tcw_func_t'(req.func))
                            FUNC_PUT:
                            begin
                                // A printable code or a tab overwrites the old cursor cell
                                // itself, so only a newline needs the separate blanking.
                                state_next = (req.char_code == CH_NEWLINE) ? ST_BLANK : ST_PUT;
                            end
                            FUNC_BACKSPACE:
                            begin
                                state_next = ST_BLANK;
                            end
                            FUNC_READ:
                            begin
                                if (index_ok)
                                begin
                                    mem_re     = 1'b1;
                                    state_next = ST_READ_DATA;
                                end
                                else
                                begin
                                    state_next = ST_RESULT;
                                end
                            end
                            FUNC_NONE:
                            begin
                                state_next = ST_RESULT;
                            end
                        endcase
                    end
                end
            end

            ST_READ_DATA:
            begin
                rd_char_next = mem_rdata[CHAR_W-1:0];
                rd_attr_next = mem_rdata[CELL_W-1:CHAR_W];
                state_next   = ST_RESULT;
            end

            ST_BLANK:
            begin
                mem_we = 1'b1;
                priority if (func_reg == FUNC_BACKSPACE)
                begin
                    if (row_reg != '0 || col_reg > COL_W'(1))
                    begin
                        if (col_reg == '0)
                        begin
                            col_next = COL_W'(COLUMNS - 1);
                            row_next = row_reg - 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg - 1'b1;
                        end
                        state_next = ST_GLYPH;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        scrolled_next = 1'b1;
                        scr_cnt_next  = '0;
                        state_next    = ST_SCROLL_COPY;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_GLYPH;
                    end
                end
            end

            ST_PUT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {ATTR_NORMAL, is_tab_reg ? CH_SPACE : ch_reg};
                tab_next  = tab_reg - 1'b1;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        scrolled_next = 1'b1;
                        scr_cnt_next  = '0;
                        state_next    = ST_SCROLL_COPY;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = (tab_next != '0) ? ST_PUT : ST_GLYPH;
                    end
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = (tab_next != '0) ? ST_PUT : ST_GLYPH;
                end
            end

            ST_SCROLL_COPY:
            begin
                // Each cell is read one row further down and written back in the next
                // cycle, one row up, so the write trails the read.
                if (scr_cnt_reg != SCR_W'(MOVE_CELLS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = base_reg + ADDR_W'(COLUMNS) + ADDR_W'(scr_cnt_reg);
                end
                if (scr_cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = base_reg + ADDR_W'(scr_cnt_reg) - 1'b1;
                    mem_wdata = mem_rdata;
                end
                if (scr_cnt_reg == SCR_W'(MOVE_CELLS))
                begin
                    scr_cnt_next = '0;
                    state_next   = ST_SCROLL_FILL;
                end
                else
                begin
                    scr_cnt_next = scr_cnt_reg + 1'b1;
                end
            end

            ST_SCROLL_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + ADDR_W'(MOVE_CELLS) + ADDR_W'(scr_cnt_reg);
                if (scr_cnt_reg == SCR_W'(COLUMNS - 1))
                begin
                    state_next = (tab_reg != '0) ? ST_PUT : ST_GLYPH;
                end
                else
                begin
                    scr_cnt_next = scr_cnt_reg + 1'b1;
                end
            end

            ST_GLYPH:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {ATTR_NORMAL, glyph};
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    cur_we     = !term_bad_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && !term_bad_reg) |->
            (32'(col_reg) < 32'(COLUMNS) && 32'(row_reg) < 32'(ROWS)))
        else $error("cursor left the screen");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.scrolled) |-> row_last)
        else $error("scroll reported with cursor off the last row");

    a_copy_lag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL_COPY && mem_we && mem_re) |->
            (mem_raddr == mem_waddr + ADDR_W'(COLUMNS + 1)))
        else $error("scroll copy read and write out of step");

    a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after its result");

endmodule

>>> rtl/text_console_writer.sv
// Character-cell text terminal: NUM_TERMINALS screens of COLUMNS x ROWS cells kept in one
// synchronous cell memory, each with its own cursor. A request prints a character (newline
// and tab included), steps the cursor back, or reads one cell, and gives exactly one
// response with the cursor after the request. Requests are handled one at a time by a
// sequencer that does one memory write per cycle while it works on a request. A backspace
// on one of the first two cells leaves the cursor where it is, a read of a cell index
// beyond the screen does not read the memory, and an unused function or an absent
// terminal goes straight to the response; every response is held until the response
// register is free. A scroll moves the screen up through the cell memory, one cell per
// cycle. After reset the memory is swept to blanks before the first request is accepted;
// the cursor glyph register can be written at any time the block is idle.
module text_console_writer import tcw_pkg::*; #(
    parameter int NUM_TERMINALS = NUM_TERMINALS_DEF,
    parameter int COLUMNS       = COLUMNS_DEF,
    parameter int ROWS          = ROWS_DEF,
    parameter int TAB_SPACES    = TAB_SPACES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcw_req_if.sink    req,
    tcw_rsp_if.source  rsp,
    tcw_cfg_if.sink    cfg
);

    localparam int DEPTH  = NUM_TERMINALS * ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CHAR_W-1:0] glyph_reg, glyph_next;
    logic              out_valid_reg, out_valid_next;
    tcw_result_t       out_data_reg, out_data_next;

    logic              res_valid;
    logic              res_ready;
    tcw_result_t       res;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    assign cfg.ready = 1'b1;
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        glyph_next     = glyph_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cfg.valid)
        begin
            glyph_next = cfg.data;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_reg     <= GLYPH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            glyph_reg     <= glyph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_col = out_data_reg.cursor_col;
    assign rsp.cursor_row = out_data_reg.cursor_row;
    assign rsp.cell_char  = out_data_reg.cell_char;
    assign rsp.cell_attr  = out_data_reg.cell_attr;
    assign rsp.scrolled   = out_data_reg.scrolled;

    tcw_ctrl #(
        .NUM_TERMINALS (NUM_TERMINALS),
        .COLUMNS       (COLUMNS),
        .ROWS          (ROWS),
        .TAB_SPACES    (TAB_SPACES),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .glyph     (glyph_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tcw_cell_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> test/tb_text_console_writer.sv
module tb_text_console_writer import tcw_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT    = NUM_TERMINALS_DEF;
    localparam int COLS  = COLUMNS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = ROWS * COLS;

    localparam int ITEMS_PER_PHASE = 265;
    localparam int SCROLL_BUDGET   = 150;

    logic clk = 1'b0;
    logic rst_n;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();
    tcw_cfg_if cfg_ch ();

    text_console_writer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the terminal state.
    logic [CELL_W-1:0] screen_mem [NT][CELLS];
    int                cursor_lin [NT];
    logic [CHAR_W-1:0] glyph_model;
    int                scroll_total;

    tcw_result_t cursor_reports [$];
    int          error_count;
    int          burst_left;
    int          rx_hold_cycles;

    function automatic void reset_console();
        int t;
        int i;
        for (t = 0; t < NT; t++)
        begin
            for (i = 0; i < CELLS; i++)
                screen_mem[t][i] = BLANK_CELL;
            cursor_lin[t] = 0;
        end
        glyph_model  = GLYPH_RESET;
        scroll_total = 0;
    endfunction

    function automatic void store_cell(int t, int x, int y, logic [CHAR_W-1:0] ch);
        if (x < COLS && y * COLS + x < CELLS)
            screen_mem[t][y * COLS + x] = {ATTR_NORMAL, ch};
    endfunction

    function automatic void roll_screen(int t);
        int i;
        for (i = 0; i < CELLS - COLS; i++)
            screen_mem[t][i] = screen_mem[t][i + COLS];
        for (i = CELLS - COLS; i < CELLS; i++)
            screen_mem[t][i] = BLANK_CELL;
        scroll_total++;
    endfunction

    function automatic bit apply_wrap(int t, inout int x, inout int y);
        if (x >= COLS)
        begin
            x = 0;
            y = y + 1;
        end
        if (y >= ROWS)
        begin
            x = 0;
            y = ROWS - 1;
            roll_screen(t);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic tcw_result_t console_step(tcw_func_t f, int t, logic [CHAR_W-1:0] ch,
                                                 logic [INDEX_W-1:0] idx);
        tcw_result_t r;
        int          x;
        int          y;
        int          p;
        int          i;
        r = '0;
        if (t >= NT)
            return r;
        p = cursor_lin[t];
        x = p % COLS;
        y = p / COLS;
        case (f)
            FUNC_PUT:
            begin
                store_cell(t, x, y, CH_SPACE);
                if (ch == CH_NEWLINE)
                begin
                    x = 0;
                    y = y + 1;
                end
                else if (ch == CH_TAB)
                begin
                    // Every blank of a tab may wrap, and on the last row scroll.
                    for (i = 0; i < TAB_SPACES_DEF; i++)
                    begin
                        store_cell(t, x, y, CH_SPACE);
                        x = x + 1;
                        if (apply_wrap(t, x, y))
                            r.scrolled = 1'b1;
                    end
                end
                else
                begin
                    store_cell(t, x, y, ch);
                    x = x + 1;
                end
                if (apply_wrap(t, x, y))
                    r.scrolled = 1'b1;
                cursor_lin[t] = y * COLS + x;
                store_cell(t, x, y, glyph_model);
            end
            FUNC_BACKSPACE:
            begin
                store_cell(t, x, y, CH_SPACE);
                if (p > 1)
                begin
                    p = p - 1;
                    cursor_lin[t] = p;
                    store_cell(t, p % COLS, p / COLS, glyph_model);
                end
            end
            FUNC_READ:
            begin
                if (idx < CELLS)
                begin
                    r.cell_char = screen_mem[t][idx][7:0];
                    r.cell_attr = screen_mem[t][idx][15:8];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_col = COL_OUT_W'(cursor_lin[t] % COLS);
        r.cursor_row = ROW_OUT_W'(cursor_lin[t] / COLS);
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] printable_char();
        logic [CHAR_W-1:0] ch;
        do
            ch = CHAR_W'($urandom_range(0, 255));
        while (ch == CH_NEWLINE || ch == CH_TAB);
        return ch;
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom_range(0, 2047));
    endfunction

    // Sender: requests go out in bursts of random length with random gaps between them.
    task automatic send_request(tcw_func_t f, int t, logic [CHAR_W-1:0] ch,
                                logic [INDEX_W-1:0] idx);
        int gap;
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.terminal   <= TERM_IN_W'(t);
        req_ch.char_code  <= ch;
        req_ch.cell_index <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        cursor_reports.push_back(console_step(f, t, ch, idx));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (cursor_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_glyph(logic [CHAR_W-1:0] g);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= g;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        glyph_model = g;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Moves along the current row with tabs, then single characters.
    task automatic move_to_column(int t, int col);
        while (cursor_lin[t] % COLS + TAB_SPACES_DEF <= col)
            send_request(FUNC_PUT, t, CH_TAB, rand_index());
        while (cursor_lin[t] % COLS < col)
            send_request(FUNC_PUT, t, printable_char(), rand_index());
    endtask

    task automatic test_directed();
        send_request(FUNC_READ, 0, 8'h00, 11'd0);
        send_request(FUNC_BACKSPACE, 0, 8'h00, 11'd0);
        send_request(FUNC_PUT, 0, 8'h41, 11'd0);
        send_request(FUNC_BACKSPACE, 0, 8'h00, 11'd0);
        send_request(FUNC_PUT, 0, 8'h00, 11'd0);
        send_request(FUNC_PUT, 0, 8'hFF, 11'd0);
        send_request(FUNC_PUT, 0, 8'h7E, 11'h7FF);
        send_request(FUNC_BACKSPACE, 0, 8'h00, 11'd0);
        send_request(FUNC_PUT, 0, CH_NEWLINE, 11'd0);
        send_request(FUNC_PUT, 0, CH_TAB, 11'd0);
        send_request(FUNC_READ, 0, 8'h00, 11'd1);
        send_request(FUNC_READ, 0, 8'h00, 11'd84);
        send_request(FUNC_READ, 0, 8'h00, 11'(CELLS - 1));
        send_request(FUNC_READ, 0, 8'h00, 11'(CELLS));
        send_request(FUNC_READ, 0, 8'h00, 11'h7FF);
        send_request(FUNC_NONE, 3, 8'hFF, 11'h7FF);
        send_request(FUNC_PUT, 3, 8'h5A, 11'd0);
        // Terminal 2: step back from the start of row 1 to the last column of row 0.
        send_request(FUNC_PUT, 2, CH_NEWLINE, 11'd0);
        send_request(FUNC_BACKSPACE, 2, 8'h00, 11'd0);
        send_request(FUNC_PUT, 2, 8'h23, 11'd0);
        send_request(FUNC_BACKSPACE, 2, 8'h00, 11'd0);
        send_request(FUNC_PUT, 2, CH_TAB, 11'd0);
        send_request(FUNC_READ, 2, 8'h00, 11'(COLS - 1));
        send_request(FUNC_PUT, 1, 8'h80, 11'd0);
        send_request(FUNC_READ, 1, 8'h00, 11'd1);
    endtask

    task automatic test_scroll_and_wrap();
        int t;
        for (t = 0; t < NT; t++)
        begin
            while (cursor_lin[t] / COLS < ROWS - 1)
                send_request(FUNC_PUT, t, CH_NEWLINE, rand_index());
            send_request(FUNC_PUT, t, printable_char(), rand_index());
            send_request(FUNC_PUT, t, CH_NEWLINE, rand_index());
            send_request(FUNC_READ, t, 8'h00, 11'((ROWS - 2) * COLS));
            move_to_column(t, COLS - 1);
            send_request(FUNC_PUT, t, printable_char(), rand_index());
            move_to_column(t, COLS - 2);
            send_request(FUNC_PUT, t, CH_TAB, rand_index());
            send_request(FUNC_READ, t, 8'h00, 11'((ROWS - 2) * COLS + COLS - 1));
            send_request(FUNC_BACKSPACE, t, 8'h00, rand_index());
            send_request(FUNC_BACKSPACE, t, 8'h00, rand_index());
            move_to_column(t, COLS - TAB_SPACES_DEF);
            send_request(FUNC_PUT, t, CH_TAB, rand_index());
            repeat (3)
                send_request(FUNC_READ, t, 8'h00,
                             11'($urandom_range(CELLS - 2 * COLS, CELLS - 1)));
        end
    endtask

    task automatic send_random_request();
        int                 sel;
        int                 t;
        int                 lin;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        sel = $urandom_range(0, 99);
        t   = $urandom_range(0, NT - 1);
        idx = rand_index();
        if (sel < 55)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 7 && scroll_total < SCROLL_BUDGET)
                ch = CH_NEWLINE;
            else if (sel < 15)
                ch = CH_TAB;
            else
                ch = CHAR_W'($urandom_range(0, 255));
            send_request(FUNC_PUT, t, ch, idx);
        end
        else if (sel < 70)
            send_request(FUNC_BACKSPACE, t, CHAR_W'($urandom_range(0, 255)), idx);
        else if (sel < 95)
        begin
            // Half the reads land just behind the cursor, where the text is.
            sel = $urandom_range(0, 9);
            if (sel < 5)
            begin
                lin = cursor_lin[t] - $urandom_range(0, 2 * COLS);
                idx = INDEX_W'((lin < 0) ? 0 : lin);
            end
            else if (sel == 9)
                idx = INDEX_W'($urandom_range(CELLS, 2047));
            send_request(FUNC_READ, t, CHAR_W'($urandom_range(0, 255)), idx);
        end
        else
            send_request(FUNC_NONE, t, CHAR_W'($urandom_range(0, 255)), idx);
    endtask

    task automatic test_random_phase(logic [CHAR_W-1:0] g, bit hold_receiver);
        int n;
        wait_drained();
        write_glyph(g);
        for (n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            // The receiver then holds off while requests keep coming.
            if (hold_receiver && n == 5)
                rx_hold_cycles = 400;
            if (n % 97 == 96)
                wait_drained();
            send_random_request();
        end
    endtask

    // Receiver: stalls never, at random or on a rotating pattern, in a mode that changes from one stretch to the next.
    initial
    begin
        int                seg_left;
        int                mode;
        logic [7:0]        pattern;
        seg_left       = 0;
        mode           = 0;
        pattern        = 8'hFF;
        rx_hold_cycles = 0;
        rsp_ch.ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 200);
                pattern  = 8'($urandom_range(0, 255)) | 8'h01;
            end
            seg_left--;
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                rsp_ch.ready <= 1'b1;
            else if (mode == 1)
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            else
            begin
                rsp_ch.ready <= pattern[0];
                pattern = {pattern[0], pattern[7:1]};
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        tcw_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (cursor_reports.size() == 0)
            begin
                $display("%0t: response with no request outstanding, expected none, actual %p",
                         $time, {rsp_ch.cursor_col, rsp_ch.cursor_row, rsp_ch.cell_char,
                                 rsp_ch.cell_attr, rsp_ch.scrolled});
                error_count++;
            end
            else
            begin
                want = cursor_reports.pop_front();
                check_field("cursor_col", want.cursor_col, rsp_ch.cursor_col);
                check_field("cursor_row", want.cursor_row, rsp_ch.cursor_row);
                check_field("cell_char", want.cell_char, rsp_ch.cell_char);
                check_field("cell_attr", want.cell_attr, rsp_ch.cell_attr);
                check_field("scrolled", want.scrolled, rsp_ch.scrolled);
            end
        end
    end

    initial
    begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_PUT;
        req_ch.terminal   = '0;
        req_ch.char_code  = '0;
        req_ch.cell_index = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        error_count       = 0;
        burst_left        = 0;
        reset_console();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        wait_drained();
        write_glyph(8'h00);
        test_scroll_and_wrap();
        test_random_phase(8'hFF, 1'b0);
        test_random_phase(8'h00, 1'b1);
        test_random_phase(CHAR_W'($urandom_range(0, 255)), 1'b0);
        test_random_phase(CHAR_W'($urandom_range(0, 255)), 1'b0);

        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
